@@ design/ipv4al_pkg.sv @@
// Shared types and codes for the IPv4 address list table.
package ipv4al_pkg;

	// Default number of entries in the list
	localparam int CAPACITY_DEF = 64;

	// Address width
	localparam int ADDR_W = 32;

	// Operation codes on the kind port
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_CHECK  = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// Width of the entry_count port
	localparam int COUNT_W = 7;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic init;   // drop a fresh probe token at the newest entry, clear visit marks
		logic shift;  // close the gap: marked cells take their upper neighbour
		logic write;  // append: the cell at the fill index takes the new address
	} cell_ctl_t;

endpackage

@@ design/ipv4al_cell.sv @@
// One list cell: an address register, a probe token and a visit mark.
module ipv4al_cell
	import ipv4al_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic              is_top,
	input  logic              is_tail,
	input  logic [ADDR_W-1:0] key,
	input  logic [ADDR_W-1:0] wdata,
	input  logic [ADDR_W-1:0] up_entry,
	input  logic              up_token,
	output logic [ADDR_W-1:0] entry,
	output logic              tok_out,
	output logic              hit
);

	logic [ADDR_W-1:0] entry_q;
	logic              token_q;
	logic              visited_q;
	logic              match;

	// Compare against the broadcast key; the token stops where it matches
	assign match   = (entry_q == key);
	assign hit     = token_q & match;
	assign tok_out = token_q & ~match;
	assign entry   = entry_q;

	// Token walks down one cell a cycle; visited cells are above the hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q   <= 1'b0;
			visited_q <= 1'b0;
		end else if (ctl.init) begin
			token_q   <= is_top;
			visited_q <= 1'b0;
		end else begin
			token_q   <= up_token;
			visited_q <= visited_q | token_q;
		end
	end

	// Entry storage: append write or shift-down from the upper neighbour
	always_ff @(posedge clk) begin
		if (ctl.write && is_tail) begin
			entry_q <= wdata;
		end else if (ctl.shift && (visited_q || token_q)) begin
			entry_q <= up_entry;
		end
	end

endmodule

@@ design/ipv4_address_list_table.sv @@
// Top level of the IPv4 address list table: sequencer and row of cells.
//
//  channel   signals                          beat taken when
//  command   start, kind, address, busy       start high and busy low
//  result    done, status, entry_count        done high (one cycle, no stall)
//
// Append, an unused kind, and remove or check on an empty list: result shows
// the cycle after the command; busy stays low.
// Remove or check: a probe token walks down the cells from the newest entry, one
// cell a cycle; the result shows after a hit, or after cell 0 is passed on a miss.
// Busy is high during the walk.
// A remove closes the gap in the same cycle as the hit. Reset empties the list.
module ipv4_address_list_table
	import ipv4al_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         kind,
	input  logic [ADDR_W-1:0]  address,
	output logic               busy,
	output logic               done,
	output logic [1:0]         status,
	output logic [COUNT_W-1:0] entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic SM_IDLE = 1'b0;
	localparam logic SM_SCAN = 1'b1;

	logic               state_q;
	logic [CW-1:0]      fill_q;
	logic [IW-1:0]      pos_q;
	logic               done_q;
	logic [1:0]         op_q;
	logic [ADDR_W-1:0]  key_q;
	logic [1:0]         status_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               any_hit;
	cell_ctl_t          ctl;

	logic [ADDR_W-1:0]  entry_w [CAPACITY];
	logic [CAPACITY-1:0] tok_w;
	logic [CAPACITY-1:0] hit_w;

	assign busy    = (state_q == SM_SCAN);
	assign accept  = start & ~busy;
	assign any_hit = |hit_w;

	// Cell controls
	always_comb begin
		ctl.init  = accept && (kind == KIND_REMOVE || kind == KIND_CHECK)
			&& (fill_q != '0);
		ctl.write = accept && (kind == KIND_APPEND) && (fill_q < CW'(CAPACITY));
		ctl.shift = busy && any_hit && (op_q == KIND_REMOVE);
	end

	// Row of cells, each fed by its upper neighbour
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ADDR_W-1:0] up_entry;
		logic              up_token;

		if (i == CAPACITY - 1) begin : g_end
			assign up_entry = entry_w[i];
			assign up_token = 1'b0;
		end else begin : g_mid
			assign up_entry = entry_w[i+1];
			assign up_token = tok_w[i+1];
		end

		ipv4al_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.is_top   (fill_q == CW'(i + 1)),
			.is_tail  (fill_q == CW'(i)),
			.key      (key_q),
			.wdata    (address),
			.up_entry (up_entry),
			.up_token (up_token),
			.entry    (entry_w[i]),
			.tok_out  (tok_w[i]),
			.hit      (hit_w[i])
		);
	end

	// Sequencer: fill count, walk position and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
			fill_q  <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				unique case (kind)
					KIND_APPEND: begin
						done_q <= 1'b1;
						if (fill_q < CW'(CAPACITY)) begin
							fill_q <= fill_q + CW'(1);
						end
					end
					KIND_REMOVE, KIND_CHECK: begin
						if (fill_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= SM_SCAN;
							pos_q   <= IW'(fill_q - CW'(1));
						end
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy) begin
				if (any_hit) begin
					done_q  <= 1'b1;
					state_q <= SM_IDLE;
					if (op_q == KIND_REMOVE) begin
						fill_q <= fill_q - CW'(1);
					end
				end else if (pos_q == '0) begin
					done_q  <= 1'b1;
					state_q <= SM_IDLE;
				end else begin
					pos_q <= pos_q - IW'(1);
				end
			end
		end
	end

	// Command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= kind;
			key_q <= address;
			unique case (kind)
				KIND_APPEND: begin
					if (fill_q < CW'(CAPACITY)) begin
						status_q <= ST_DONE;
						count_q  <= COUNT_W'(fill_q + CW'(1));
					end else begin
						status_q <= ST_FULL;
						count_q  <= COUNT_W'(fill_q);
					end
				end
				default: begin
					status_q <= ST_ABSENT;
					count_q  <= COUNT_W'(fill_q);
				end
			endcase
		end else if (busy) begin
			if (any_hit) begin
				status_q <= ST_DONE;
				if (op_q == KIND_REMOVE) begin
					count_q <= COUNT_W'(fill_q - CW'(1));
				end else begin
					count_q <= COUNT_W'(fill_q);
				end
			end else begin
				status_q <= ST_ABSENT;
				count_q  <= COUNT_W'(fill_q);
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = count_q;

endmodule

@@ design/ipv4al_checker.sv @@
// Port-level checks for the IPv4 address list table, bound to the top level.
module ipv4al_checker
	import ipv4al_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic [1:0]         kind,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [COUNT_W-1:0] entry_count
);

	// An append never walks the list: its result beat follows at once
	a_append_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == KIND_APPEND) |=> (done && !busy))
		else $error("append result not delivered in the next cycle");

	// A walk only begins from an accepted command
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// The end of a walk always delivers its result beat
	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	// A full status only when the list is at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (entry_count == COUNT_W'(CAPACITY)))
		else $error("full status with list below capacity");

	// No result beat while a walk is still running
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> !done)
		else $error("result beat during a walk");

endmodule

bind ipv4_address_list_table ipv4al_checker #(.CAPACITY(CAPACITY)) u_ipv4al_checker (.*);

@@ test/ipv4al_result_checker.sv @@
// Result checker for the IPv4 address list table: shadow list, expected beats, comparison.
module ipv4al_result_checker
	import ipv4al_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         kind,
	input  logic [ADDR_W-1:0]  address,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [COUNT_W-1:0] entry_count,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
	} list_outcome_t;

	// Shadow copy of the address list
	logic [ADDR_W-1:0] shadow_list [CAPACITY];
	int                shadow_fill;

	// Outcomes still owed by the block, oldest first
	list_outcome_t owed_outcomes [$];
	int            bad_beats;

	initial begin
		fail_count = 0;
		pending    = 0;
		bad_beats  = 0;
	end

	// Apply one command to the shadow list and return what the block must report
	function automatic list_outcome_t apply_list_command(logic [1:0] op, logic [ADDR_W-1:0] addr);
		list_outcome_t res;
		int            last_hit;
		last_hit   = -1;
		res.status = ST_ABSENT;
		// last matching entry wins
		for (int i = 0; i < shadow_fill; i++)
			if (shadow_list[i] == addr)
				last_hit = i;
		case (op)
			KIND_APPEND: begin
				if (shadow_fill >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					shadow_list[shadow_fill] = addr;
					shadow_fill++;
					res.status = ST_DONE;
				end
			end
			KIND_REMOVE: begin
				if (last_hit >= 0) begin
					// close the gap, keeping order
					for (int i = last_hit; i + 1 < shadow_fill; i++)
						shadow_list[i] = shadow_list[i + 1];
					shadow_fill--;
					res.status = ST_DONE;
				end
			end
			KIND_CHECK: begin
				if (last_hit >= 0)
					res.status = ST_DONE;
			end
			default: ;
		endcase
		res.count = shadow_fill[COUNT_W-1:0];
		return res;
	endfunction

	// Result beats are checked before the command beat of the same edge is booked
	always @(posedge clk or negedge arst_n) begin
		list_outcome_t want;
		if (!arst_n) begin
			shadow_fill = 0;
			owed_outcomes.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (owed_outcomes.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%t: result beat with nothing owed: status %0d count %0d",
							$realtime, status, entry_count);
				end else begin
					want = owed_outcomes.pop_front();
					if (want.status !== status || want.count !== entry_count) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display("%t: mismatch: status exp %0d got %0d, count exp %0d got %0d",
								$realtime, want.status, status, want.count, entry_count);
					end
				end
			end
			if (start && !busy)
				owed_outcomes.push_back(apply_list_command(kind, address));
			pending    <= owed_outcomes.size();
			fail_count <= bad_beats;
		end
	end

endmodule

@@ test/tb_ipv4_address_list_table.sv @@
// Testbench top for the IPv4 address list table: clock, reset, command stimulus and verdict.
module tb_ipv4_address_list_table
	import ipv4al_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CAPACITY    = CAPACITY_DEF;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int         RANDOM_OPS  = 1250;
	localparam int         CYCLE_LIMIT = 600000;
	localparam int         DRAIN_WAIT  = CAPACITY + 6;

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               start   = 1'b0;
	logic [1:0]         kind    = KIND_APPEND;
	logic [ADDR_W-1:0]  address = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [COUNT_W-1:0] entry_count;
	int                 fail_count;
	int                 pending;

	int                cycle_count = 0;
	int                idle_pct    = 0;
	logic [ADDR_W-1:0] addr_pool [8];

	always #2 clk = ~clk;

	ipv4_address_list_table #(.CAPACITY(CAPACITY)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.address    (address),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.entry_count(entry_count)
	);

	ipv4al_result_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.address    (address),
		.done       (done),
		.status     (status),
		.entry_count(entry_count),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Drive one command beat, with an optional gap first; returns on the accepting edge
	task automatic send_command(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start   <= 1'b1;
		kind    <= op;
		address <= addr;
		do @(posedge clk); while (busy);
	endtask

	// Mostly addresses from a small pool so removes and checks hit
	function automatic logic [ADDR_W-1:0] pick_address();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return addr_pool[$urandom_range(7)];
		if (roll < 80)
			return ($urandom_range(1) != 0) ? '1 : '0;
		return $urandom;
	endfunction

	// Filling leans on append, draining on remove; a few unused kinds as noise
	function automatic logic [1:0] pick_kind(bit filling);
		int roll;
		roll = $urandom_range(99);
		if (filling) begin
			if (roll < 65) return KIND_APPEND;
			if (roll < 85) return KIND_REMOVE;
			if (roll < 97) return KIND_CHECK;
		end else begin
			if (roll < 15) return KIND_APPEND;
			if (roll < 70) return KIND_REMOVE;
			if (roll < 95) return KIND_CHECK;
		end
		return KIND_UNUSED;
	endfunction

	initial begin
		bit filling;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty list, duplicates, head/middle/tail removal, unused kind
		send_command(KIND_CHECK,  32'h0000_0000);
		send_command(KIND_REMOVE, 32'hFFFF_FFFF);
		send_command(KIND_UNUSED, 32'h1234_5678);
		send_command(KIND_APPEND, 32'h0000_0000);
		send_command(KIND_APPEND, 32'hFFFF_FFFF);
		send_command(KIND_APPEND, 32'h0000_0000);
		send_command(KIND_APPEND, 32'hA5A5_A5A5);
		send_command(KIND_CHECK,  32'hFFFF_FFFF);
		send_command(KIND_CHECK,  32'h5A5A_5A5A);
		send_command(KIND_REMOVE, 32'h0000_0000);
		send_command(KIND_CHECK,  32'h0000_0000);
		send_command(KIND_REMOVE, 32'hA5A5_A5A5);
		send_command(KIND_REMOVE, 32'h0000_0000);
		send_command(KIND_REMOVE, 32'h0000_0000);
		send_command(KIND_UNUSED, 32'hFFFF_FFFF);
		send_command(KIND_REMOVE, 32'hFFFF_FFFF);
		send_command(KIND_APPEND, 32'h8000_0001);
		send_command(KIND_CHECK,  32'h8000_0001);

		// Random: alternate fill and drain stretches so the list hits full and empty
		filling = 1'b1;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n < RANDOM_OPS / 3)
				idle_pct = 29;
			else if (n < 2 * RANDOM_OPS / 3)
				idle_pct = 59;
			else
				idle_pct = 0;
			if (n % 120 == 0) begin
				filling = (n / 120) % 2 == 0;
				foreach (addr_pool[i])
					addr_pool[i] = $urandom;
			end
			send_command(pick_kind(filling), pick_address());
		end
		start <= 1'b0;

		// Let every owed result arrive, then allow for a late stray beat
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
